// File: rtl/a64dec_pkg.sv
// ----------------------------------------------------------------------------
// a64dec_pkg
// Shared types and constants for the ARM64 subset instruction decoder:
// operation codes, ALU operation codes, control bit positions and the
// decoded result record.
// ----------------------------------------------------------------------------
package a64dec_pkg;

  // Operation codes; the opcode table produces all of them but LSL and LSR.
  typedef enum logic [4:0] {
    OPC_ERR   = 5'd0,
    OPC_LDURB = 5'd1,
    OPC_LDUR  = 5'd2,
    OPC_STURB = 5'd3,
    OPC_STUR  = 5'd4,
    OPC_MOVK  = 5'd5,
    OPC_MOVZ  = 5'd6,
    OPC_ADDI  = 5'd7,
    OPC_ADDS  = 5'd8,
    OPC_SUBS  = 5'd9,
    OPC_MVN   = 5'd10,
    OPC_ORR   = 5'd11,
    OPC_EOR   = 5'd12,
    OPC_ANDS  = 5'd13,
    OPC_LSL   = 5'd14,
    OPC_LSR   = 5'd15,
    OPC_UBFM  = 5'd16,
    OPC_ASR   = 5'd17,
    OPC_B     = 5'd18,
    OPC_BCOND = 5'd19,
    OPC_BL    = 5'd20,
    OPC_RET   = 5'd21,
    OPC_NOP   = 5'd22,
    OPC_HLT   = 5'd23
  } opcode_e;

  // ALU operation codes.
  typedef enum logic [3:0] {
    ALU_PLUS  = 4'd0,
    ALU_MINUS = 4'd1,
    ALU_NOT   = 4'd2,
    ALU_OR    = 4'd3,
    ALU_XOR   = 4'd4,
    ALU_AND   = 4'd5,
    ALU_MOV   = 4'd6,
    ALU_LSL   = 4'd7,
    ALU_LSR   = 4'd8,
    ALU_ASR   = 4'd9,
    ALU_PASSA = 4'd10
  } alu_op_e;

  // Control bit positions.
  localparam int unsigned CtlMemRead  = 0;
  localparam int unsigned CtlMemWrite = 1;
  localparam int unsigned CtlLoadSel  = 2;
  localparam int unsigned CtlLinkDest = 3;
  localparam int unsigned CtlRegWrite = 4;
  localparam int unsigned CtlSetFlags = 5;
  localparam int unsigned CtlImmOp    = 6;
  localparam int unsigned CtlBaseSp   = 7;
  localparam int unsigned CtlStoreSrc = 8;
  localparam int unsigned CtlWidth    = 9;

  // Fixed register numbers.
  localparam logic [4:0] RegLink = 5'd30;
  localparam logic [4:0] RegZero = 5'd31;

  // One decoded instruction.
  typedef struct packed {
    opcode_e               opcode;
    alu_op_e               alu_operation;
    logic [CtlWidth-1:0]   control_bits;
    logic [15:0]           immediate;
    logic [5:0]            move_shift;
    logic [3:0]            condition_code;
    logic [4:0]            first_source_reg;
    logic [4:0]            second_source_reg;
    logic [4:0]            dest_reg;
    logic [63:0]           next_pc;
    logic [63:0]           sequential_pc;
  } decode_result_t;

endpackage

// File: rtl/arm64_subset_instruction_decoder.sv
// ----------------------------------------------------------------------------
// arm64_subset_instruction_decoder
// An accepted transaction is held in the input register, decoded and then
// captured in the result register. Throughput: one transaction per cycle
// while the result is not stalled; a stalled result also stalls the input
// once the input register is full.
// Reset: the valid flags of both registers clear; no payload is reset.
// ----------------------------------------------------------------------------
module arm64_subset_instruction_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] insn_word_i,
  input  logic [63:0] fetch_pc_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  opcode_o,
  output logic [3:0]  alu_operation_o,
  output logic [8:0]  control_bits_o,
  output logic [15:0] immediate_o,
  output logic [5:0]  move_shift_o,
  output logic [3:0]  condition_code_o,
  output logic [4:0]  first_source_reg_o,
  output logic [4:0]  second_source_reg_o,
  output logic [4:0]  dest_reg_o,
  output logic [63:0] next_pc_o,
  output logic [63:0] sequential_pc_o
);
  import a64dec_pkg::*;

  logic           in_valid_q;
  logic [31:0]    insn_q;
  logic [63:0]    pc_q;
  logic           out_valid_q;
  decode_result_t result_q;
  decode_result_t result_d;
  logic           stage_adv;

  // The result stage takes a new entry when it is empty or being drained.
  assign stage_adv  = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !stage_adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      insn_q <= insn_word_i;
      pc_q   <= fetch_pc_i;
    end
  end

  // Decode logic.
  a64dec_decode u_decode (
    .insn_i   (insn_q),
    .pc_i     (pc_q),
    .result_o (result_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_adv && in_valid_q) begin
      result_q <= result_d;
    end
  end

  // Output ports.
  assign out_valid_o         = out_valid_q;
  assign opcode_o            = result_q.opcode;
  assign alu_operation_o     = result_q.alu_operation;
  assign control_bits_o      = result_q.control_bits;
  assign immediate_o         = result_q.immediate;
  assign move_shift_o        = result_q.move_shift;
  assign condition_code_o    = result_q.condition_code;
  assign first_source_reg_o  = result_q.first_source_reg;
  assign second_source_reg_o = result_q.second_source_reg;
  assign dest_reg_o          = result_q.dest_reg;
  assign next_pc_o           = result_q.next_pc;
  assign sequential_pc_o     = result_q.sequential_pc;

endmodule

// File: rtl/a64dec_decode.sv
// ----------------------------------------------------------------------------
// a64dec_decode
// Combinational decode of one instruction word and its PC into the opcode,
// ALU operation, control bits, immediate, register numbers and next PCs.
// ----------------------------------------------------------------------------
module a64dec_decode (
  input  logic [31:0]                insn_i,
  input  logic [63:0]                pc_i,
  output a64dec_pkg::decode_result_t result_o
);
  import a64dec_pkg::*;

  opcode_e       op;
  logic          is_load;
  logic          is_store;
  logic          is_mov;
  logic [63:0]   seq_pc;
  logic [63:0]   br_offset;

  // Opcode table on bits 31:21.
  always_comb begin
    case (insn_i[31:21]) inside
      11'h1c2:            op = OPC_LDURB;
      11'h7c2:            op = OPC_LDUR;
      11'h1c0:            op = OPC_STURB;
      11'h7c0:            op = OPC_STUR;
      [11'h794:11'h797]:  op = OPC_MOVK;
      [11'h694:11'h697]:  op = OPC_MOVZ;
      [11'h488:11'h48b]:  op = OPC_ADDI;
      11'h558:            op = OPC_ADDS;
      11'h758:            op = OPC_SUBS;
      11'h551:            op = OPC_MVN;
      11'h550:            op = OPC_ORR;
      11'h650:            op = OPC_EOR;
      11'h750:            op = OPC_ANDS;
      [11'h69a:11'h69b]:  op = OPC_UBFM;
      [11'h49a:11'h49b]:  op = OPC_ASR;
      [11'h0a0:11'h0bf]:  op = OPC_B;
      [11'h2a0:11'h2a7]:  op = OPC_BCOND;
      [11'h4a0:11'h4bf]:  op = OPC_BL;
      11'h6b2:            op = OPC_RET;
      11'h6a8:            op = OPC_NOP;
      11'h6a2:            op = OPC_HLT;
      default:            op = OPC_ERR;
    endcase
  end

  assign is_load  = (op == OPC_LDUR)  || (op == OPC_LDURB);
  assign is_store = (op == OPC_STUR)  || (op == OPC_STURB);
  assign is_mov   = (op == OPC_MOVZ)  || (op == OPC_MOVK);
  assign seq_pc   = pc_i + 64'd4;

  // Word-scaled, sign-extended branch offset for the branch formats.
  always_comb begin
    case (op)
      OPC_BCOND:      br_offset = {{43{insn_i[23]}}, insn_i[23:5], 2'b00};
      OPC_B, OPC_BL:  br_offset = {{36{insn_i[25]}}, insn_i[25:0], 2'b00};
      default:        br_offset = 64'd0;
    endcase
  end

  // Result fields.
  always_comb begin
    result_o = '0;
    result_o.opcode = op;

    // ALU operation; the bitfield move is a right shift when imms is all ones.
    case (op)
      OPC_LDURB, OPC_LDUR, OPC_STURB, OPC_STUR, OPC_ADDI, OPC_ADDS:
                 result_o.alu_operation = ALU_PLUS;
      OPC_SUBS:  result_o.alu_operation = ALU_MINUS;
      OPC_MVN:   result_o.alu_operation = ALU_NOT;
      OPC_ORR:   result_o.alu_operation = ALU_OR;
      OPC_EOR:   result_o.alu_operation = ALU_XOR;
      OPC_ANDS:  result_o.alu_operation = ALU_AND;
      OPC_MOVK, OPC_MOVZ:
                 result_o.alu_operation = ALU_MOV;
      OPC_UBFM:  result_o.alu_operation = (insn_i[15:10] == 6'h3f) ? ALU_LSR : ALU_LSL;
      OPC_ASR:   result_o.alu_operation = ALU_ASR;
      default:   result_o.alu_operation = ALU_PASSA;
    endcase

    // Control bits.
    result_o.control_bits[CtlMemRead]  = is_load;
    result_o.control_bits[CtlLoadSel]  = is_load;
    result_o.control_bits[CtlMemWrite] = is_store;
    result_o.control_bits[CtlStoreSrc] = is_store;
    result_o.control_bits[CtlBaseSp]   = is_load || is_store;
    result_o.control_bits[CtlLinkDest] = (op == OPC_BL);
    result_o.control_bits[CtlSetFlags] = (op == OPC_ADDS) || (op == OPC_SUBS) ||
                                         (op == OPC_ANDS);
    case (op)
      OPC_LDURB, OPC_LDUR, OPC_MOVK, OPC_MOVZ, OPC_ADDI, OPC_ADDS, OPC_SUBS,
      OPC_MVN, OPC_ORR, OPC_EOR, OPC_ANDS, OPC_UBFM, OPC_ASR, OPC_BL:
               result_o.control_bits[CtlRegWrite] = 1'b1;
      default: result_o.control_bits[CtlRegWrite] = 1'b0;
    endcase
    // The unknown encoding also takes the immediate operand.
    case (op)
      OPC_ERR, OPC_LDURB, OPC_LDUR, OPC_STURB, OPC_STUR, OPC_MOVK, OPC_MOVZ,
      OPC_ADDI, OPC_MVN, OPC_LSL, OPC_LSR, OPC_UBFM, OPC_ASR:
               result_o.control_bits[CtlImmOp] = 1'b1;
      default: result_o.control_bits[CtlImmOp] = 1'b0;
    endcase

    // Immediate per format; formats without one give zero.
    if ((op == OPC_UBFM) || (op == OPC_ASR) || (op == OPC_ADDI)) begin
      result_o.immediate = {4'd0, insn_i[21:10]};
    end else if (is_load || is_store) begin
      result_o.immediate = {7'd0, insn_i[20:12]};
    end else if (is_mov) begin
      result_o.immediate = insn_i[20:5];
    end else begin
      result_o.immediate = 16'd0;
    end

    result_o.move_shift     = is_mov ? {insn_i[22:21], 4'd0} : 6'd0;
    result_o.condition_code = (op == OPC_BCOND) ? insn_i[3:0] : 4'd0;

    // Register numbers.
    result_o.first_source_reg  = (op == OPC_MOVZ) ? RegZero : insn_i[9:5];
    result_o.second_source_reg = is_store ? insn_i[4:0] : insn_i[20:16];
    result_o.dest_reg          = (op == OPC_BL) ? RegLink : insn_i[4:0];

    // Next PCs; branches are predicted taken.
    result_o.sequential_pc = seq_pc;
    case (op)
      OPC_B, OPC_BL, OPC_BCOND: result_o.next_pc = pc_i + br_offset;
      default:                  result_o.next_pc = seq_pc;
    endcase
  end

endmodule

// File: rtl/a64dec_checker.sv
// ----------------------------------------------------------------------------
// a64dec_checker
// Port-level checks for the instruction decoder, bound to the top level.
// ----------------------------------------------------------------------------
module a64dec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [4:0]  opcode_o,
  input logic [8:0]  control_bits_o,
  input logic [5:0]  move_shift_o,
  input logic [3:0]  condition_code_o,
  input logic [4:0]  dest_reg_o,
  input logic [63:0] next_pc_o
);
  import a64dec_pkg::*;

  // A stalled result transaction holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(opcode_o) &&
      $stable(next_pc_o))
    else $error("stalled result changed");

  // The link bit goes with a BL into register 30.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && control_bits_o[CtlLinkDest] |->
      (opcode_o == OPC_BL) && (dest_reg_o == RegLink) && control_bits_o[CtlRegWrite])
    else $error("link destination inconsistent");

  // A nonzero condition appears only on a conditional branch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (condition_code_o != 4'd0) |-> (opcode_o == OPC_BCOND))
    else $error("condition code on a non-branch");

  // A move shift appears only on the wide moves.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (move_shift_o != 6'd0) |->
      (opcode_o == OPC_MOVZ) || (opcode_o == OPC_MOVK))
    else $error("move shift on a non-move");

endmodule

bind arm64_subset_instruction_decoder a64dec_checker u_a64dec_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .opcode_o         (opcode_o),
  .control_bits_o   (control_bits_o),
  .move_shift_o     (move_shift_o),
  .condition_code_o (condition_code_o),
  .dest_reg_o       (dest_reg_o),
  .next_pc_o        (next_pc_o)
);

// File: bench/arm64_subset_instruction_decoder_test.sv
// ----------------------------------------------------------------------------
// arm64_subset_instruction_decoder_test
// Self-checking testbench for the ARM64 subset decode stage. A short directed
// set covers every table entry, unknown encodings, the shift selection of
// UBFM and wrapping branch targets. Random instruction words and PCs follow,
// under phases of sender and receiver idling and one long receiver hold-off.
// Every result transaction is checked field by field against a predictor.
// ----------------------------------------------------------------------------
module arm64_subset_instruction_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import a64dec_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned TailCycles  = 8;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned PhaseItems  = 100;

  // One instruction fetch: the word and the address it came from.
  typedef struct packed {
    logic [31:0] insn;
    logic [63:0] pc;
  } fetch_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] insn_word = '0;
  logic [63:0] fetch_pc = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  opcode;
  logic [3:0]  alu_operation;
  logic [8:0]  control_bits;
  logic [15:0] immediate;
  logic [5:0]  move_shift;
  logic [3:0]  condition_code;
  logic [4:0]  first_source_reg;
  logic [4:0]  second_source_reg;
  logic [4:0]  dest_reg;
  logic [63:0] next_pc;
  logic [63:0] sequential_pc;

  fetch_item_t    fetch_q[$];
  decode_result_t decoded_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_off = 1'b0;
  logic        offer_taken = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;

  arm64_subset_instruction_decoder u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .insn_word_i        (insn_word),
    .fetch_pc_i         (fetch_pc),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .opcode_o           (opcode),
    .alu_operation_o    (alu_operation),
    .control_bits_o     (control_bits),
    .immediate_o        (immediate),
    .move_shift_o       (move_shift),
    .condition_code_o   (condition_code),
    .first_source_reg_o (first_source_reg),
    .second_source_reg_o(second_source_reg),
    .dest_reg_o         (dest_reg),
    .next_pc_o          (next_pc),
    .sequential_pc_o    (sequential_pc)
  );

  always #5 clk_i = ~clk_i;

  // Decodes one instruction word the way the stage is specified to.
  function automatic decode_result_t predict_decode(input logic [31:0] w,
                                                    input logic [63:0] pc);
    decode_result_t r;
    opcode_e        op;
    logic [10:0]    top;
    logic           is_load;
    logic           is_store;
    logic           is_mov;
    logic [63:0]    seq;
    top = w[31:21];
    if (top == 11'h1c2) op = OPC_LDURB;
    else if (top == 11'h7c2) op = OPC_LDUR;
    else if (top == 11'h1c0) op = OPC_STURB;
    else if (top == 11'h7c0) op = OPC_STUR;
    else if (top >= 11'h794 && top <= 11'h797) op = OPC_MOVK;
    else if (top >= 11'h694 && top <= 11'h697) op = OPC_MOVZ;
    else if (top >= 11'h488 && top <= 11'h48b) op = OPC_ADDI;
    else if (top == 11'h558) op = OPC_ADDS;
    else if (top == 11'h758) op = OPC_SUBS;
    else if (top == 11'h551) op = OPC_MVN;
    else if (top == 11'h550) op = OPC_ORR;
    else if (top == 11'h650) op = OPC_EOR;
    else if (top == 11'h750) op = OPC_ANDS;
    else if (top >= 11'h69a && top <= 11'h69b) op = OPC_UBFM;
    else if (top >= 11'h49a && top <= 11'h49b) op = OPC_ASR;
    else if (top >= 11'h0a0 && top <= 11'h0bf) op = OPC_B;
    else if (top >= 11'h2a0 && top <= 11'h2a7) op = OPC_BCOND;
    else if (top >= 11'h4a0 && top <= 11'h4bf) op = OPC_BL;
    else if (top == 11'h6b2) op = OPC_RET;
    else if (top == 11'h6a8) op = OPC_NOP;
    else if (top == 11'h6a2) op = OPC_HLT;
    else op = OPC_ERR;

    is_load  = (op == OPC_LDUR) || (op == OPC_LDURB);
    is_store = (op == OPC_STUR) || (op == OPC_STURB);
    is_mov   = (op == OPC_MOVZ) || (op == OPC_MOVK);
    seq      = pc + 64'd4;

    r.opcode = op;
    case (op)
      OPC_LDURB, OPC_LDUR, OPC_STURB, OPC_STUR, OPC_ADDI, OPC_ADDS:
        r.alu_operation = ALU_PLUS;
      OPC_SUBS:          r.alu_operation = ALU_MINUS;
      OPC_MVN:           r.alu_operation = ALU_NOT;
      OPC_ORR:           r.alu_operation = ALU_OR;
      OPC_EOR:           r.alu_operation = ALU_XOR;
      OPC_ANDS:          r.alu_operation = ALU_AND;
      OPC_MOVK, OPC_MOVZ: r.alu_operation = ALU_MOV;
      OPC_UBFM:          r.alu_operation = (w[15:10] == 6'h3f) ? ALU_LSR : ALU_LSL;
      OPC_ASR:           r.alu_operation = ALU_ASR;
      default:           r.alu_operation = ALU_PASSA;
    endcase

    // Control bits; unknown encodings still carry the immediate operand bit.
    r.control_bits = '0;
    r.control_bits[CtlMemRead]  = is_load;
    r.control_bits[CtlLoadSel]  = is_load;
    r.control_bits[CtlMemWrite] = is_store;
    r.control_bits[CtlStoreSrc] = is_store;
    r.control_bits[CtlLinkDest] = (op == OPC_BL);
    r.control_bits[CtlRegWrite] = is_mov || is_load || op == OPC_ADDI ||
                                  op == OPC_UBFM || op == OPC_ASR ||
                                  op == OPC_ADDS || op == OPC_SUBS ||
                                  op == OPC_MVN || op == OPC_ORR ||
                                  op == OPC_EOR || op == OPC_ANDS ||
                                  op == OPC_BL;
    r.control_bits[CtlSetFlags] = (op == OPC_ADDS) || (op == OPC_SUBS) ||
                                  (op == OPC_ANDS);
    r.control_bits[CtlImmOp]    = (op == OPC_MVN) || (op <= OPC_ADDI) ||
                                  (op >= OPC_LSL && op <= OPC_ASR);
    r.control_bits[CtlBaseSp]   = is_load || is_store;

    if (op == OPC_UBFM || op == OPC_ASR || op == OPC_ADDI)
      r.immediate = {4'b0, w[21:10]};
    else if (is_load || is_store)
      r.immediate = {7'b0, w[20:12]};
    else if (is_mov)
      r.immediate = w[20:5];
    else
      r.immediate = '0;

    r.move_shift        = is_mov ? {w[22:21], 4'b0} : 6'd0;
    r.condition_code    = (op == OPC_BCOND) ? w[3:0] : 4'd0;
    r.first_source_reg  = (op == OPC_MOVZ) ? RegZero : w[9:5];
    r.second_source_reg = is_store ? w[4:0] : w[20:16];
    r.dest_reg          = (op == OPC_BL) ? RegLink : w[4:0];

    // Branch targets wrap modulo 2^64; conditional branches predicted taken.
    if (op == OPC_BCOND)
      r.next_pc = pc + {{43{w[23]}}, w[23:5], 2'b00};
    else if (op == OPC_B || op == OPC_BL)
      r.next_pc = pc + {{36{w[25]}}, w[25:0], 2'b00};
    else
      r.next_pc = seq;
    r.sequential_pc = seq;
    return r;
  endfunction

  // Picks an opcode field from table entry k, anywhere within its range.
  function automatic logic [10:0] legal_top(input int unsigned k);
    logic [10:0] lo;
    logic [10:0] hi;
    case (k)
      0:       begin lo = 11'h1c2; hi = 11'h1c2; end
      1:       begin lo = 11'h7c2; hi = 11'h7c2; end
      2:       begin lo = 11'h1c0; hi = 11'h1c0; end
      3:       begin lo = 11'h7c0; hi = 11'h7c0; end
      4:       begin lo = 11'h794; hi = 11'h797; end
      5:       begin lo = 11'h694; hi = 11'h697; end
      6:       begin lo = 11'h488; hi = 11'h48b; end
      7:       begin lo = 11'h558; hi = 11'h558; end
      8:       begin lo = 11'h758; hi = 11'h758; end
      9:       begin lo = 11'h551; hi = 11'h551; end
      10:      begin lo = 11'h550; hi = 11'h550; end
      11:      begin lo = 11'h650; hi = 11'h650; end
      12:      begin lo = 11'h750; hi = 11'h750; end
      13:      begin lo = 11'h69a; hi = 11'h69b; end
      14:      begin lo = 11'h49a; hi = 11'h49b; end
      15:      begin lo = 11'h0a0; hi = 11'h0bf; end
      16:      begin lo = 11'h2a0; hi = 11'h2a7; end
      17:      begin lo = 11'h4a0; hi = 11'h4bf; end
      18:      begin lo = 11'h6b2; hi = 11'h6b2; end
      19:      begin lo = 11'h6a8; hi = 11'h6a8; end
      default: begin lo = 11'h6a2; hi = 11'h6a2; end
    endcase
    return lo + 11'($urandom_range(hi - lo));
  endfunction

  // Mostly known encodings with random operands, some pure noise; PCs lean
  // toward both ends of the address space so that wrapping is exercised.
  function automatic fetch_item_t random_fetch();
    fetch_item_t it;
    if ($urandom_range(99) < 85)
      it.insn = {legal_top($urandom_range(20)), 21'($urandom)};
    else
      it.insn = $urandom;
    if ($urandom_range(3) == 0)
      it.insn[15:10] = 6'h3f;
    case ($urandom_range(3))
      0:       it.pc = 64'($urandom_range(255));
      1:       it.pc = 64'hffff_ffff_ffff_ff00 | 64'($urandom_range(255));
      default: it.pc = {$urandom, $urandom};
    endcase
    return it;
  endfunction

  task automatic queue_fetch(input logic [31:0] w, input logic [63:0] pc);
    fetch_item_t it;
    it.insn = w;
    it.pc = pc;
    fetch_q.push_back(it);
  endtask

  task automatic wait_drained();
    while (fetch_q.size() != 0 || decoded_q.size() != 0)
      @(negedge clk_i);
  endtask

  // One phase of random traffic under the given idling mix.
  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input bit with_hold);
    @(posedge clk_i);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    if (with_hold) begin
      hold_off = 1'b1;
      fork
        begin
          repeat (HoldCycles) @(posedge clk_i);
          hold_off = 1'b0;
        end
      join_none
    end
    repeat (PhaseItems) fetch_q.push_back(random_fetch());
    wait_drained();
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Driver: offers pending fetches and drives the result stall.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || offer_taken) begin
        offer_taken = 1'b0;
        if (fetch_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid  <= 1'b1;
          insn_word <= fetch_q[0].insn;
          fetch_pc  <= fetch_q[0].pc;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: records accepted fetches and checks each result transaction.
  always @(posedge clk_i) begin : monitor
    decode_result_t want;
    if (rst_ni) begin
      cycle_count++;
      if (in_valid && !in_stall) begin
        decoded_q.push_back(predict_decode(insn_word, fetch_pc));
        fetch_q.delete(0);
        offer_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result transaction: expected none, actual opcode %h",
                   $time, opcode);
          mismatch_count++;
        end else begin
          want = decoded_q.pop_front();
          compare_field("opcode", want.opcode, opcode);
          compare_field("alu_operation", want.alu_operation, alu_operation);
          compare_field("control_bits", want.control_bits, control_bits);
          compare_field("immediate", want.immediate, immediate);
          compare_field("move_shift", want.move_shift, move_shift);
          compare_field("condition_code", want.condition_code, condition_code);
          compare_field("first_source_reg", want.first_source_reg, first_source_reg);
          compare_field("second_source_reg", want.second_source_reg, second_source_reg);
          compare_field("dest_reg", want.dest_reg, dest_reg);
          compare_field("next_pc", want.next_pc, next_pc);
          compare_field("sequential_pc", want.sequential_pc, sequential_pc);
        end
      end
      if (cycle_count >= CycleLimit) begin
        $display("arm64_subset_instruction_decoder_test: FAIL");
        $finish;
      end
    end
  end

  // Stimulus sequence: reset, directed cases, then the random phases.
  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: unknown encodings at both extremes, every table entry,
    // UBFM decoding as a right shift, and a forward branch past the top.
    @(posedge clk_i);
    queue_fetch(32'h0000_0000, 64'h0);
    queue_fetch(32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
    for (int unsigned k = 0; k <= 20; k++)
      queue_fetch({legal_top(k), 21'($urandom)}, {$urandom, $urandom});
    queue_fetch({11'h69a, 5'd3, 6'h3f, 5'd7, 5'd9}, 64'h0000_0000_0000_1000);
    queue_fetch({11'h0af, 21'h1f_ffff}, 64'hffff_ffff_ffff_fff0);
    wait_drained();

    run_phase(0, 0, 1'b0);
    run_phase(66, 0, 1'b0);
    run_phase(0, 66, 1'b0);
    run_phase(36, 36, 1'b0);
    run_phase(0, 0, 1'b1);

    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && decoded_q.size() == 0)
      $display("arm64_subset_instruction_decoder_test: PASS");
    else
      $display("arm64_subset_instruction_decoder_test: FAIL");
    $finish;
  end

endmodule
